// ===== hw/rtl/tfn_pkg.sv =====
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared widths and types for the triangle face normal block.
// ----------------------------------------------------------------------------
package tfn_pkg;

  localparam int PW    = 32;   // corner coordinate width, Q16.16
  localparam int DW    = 33;   // edge vector component width
  localparam int CW    = 66;   // cross product component width, signed
  localparam int MW    = 65;   // cross product magnitude width
  localparam int LOW   = 32;   // low half of a magnitude for squaring
  localparam int HIW   = MW - LOW;
  localparam int SQW   = 130;  // square of one component
  localparam int SW    = 132;  // sum of three squares
  localparam int WIDE  = 164;  // working width of the quotient search
  localparam int QW    = 15;   // quotient bits, 0..16384
  localparam int NSTEP = QW;
  localparam int FRAC_SHIFT = 28;  // 2 * 14 fraction bits
  localparam int OUTW  = 16;
  localparam int LANES = 3;

  typedef struct packed {
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [CW-1:0] r_z;
    logic                 degenerate;
  } mid_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

// ===== hw/rtl/tfn_queue.sv =====
// ----------------------------------------------------------------------------
// tfn_queue
// Short first-in first-out queue between the front and back pipelines.
// ----------------------------------------------------------------------------
module tfn_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  tfn_pkg::mid_t       din,
  input  logic                rd,
  output tfn_pkg::mid_t       dout,
  output tfn_pkg::queue_stat_t stat
);
  import tfn_pkg::*;

  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  mid_t           mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CNW-1:0] count;

  assign stat.full  = (count == CNW'(DEPTH));
  assign stat.empty = (count == '0);
  assign dout       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (wr && !rd) begin
        count <= count + CNW'(1);
      end else if (rd && !wr) begin
        count <= count - CNW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/tfn_front.sv =====
// ----------------------------------------------------------------------------
// tfn_front
// Takes triangles, forms edge vectors and the exact cross product, and flags
// degenerate triangles.
// ----------------------------------------------------------------------------
module tfn_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic signed [31:0]          point_a_x,
  input  logic signed [31:0]          point_a_y,
  input  logic signed [31:0]          point_a_z,
  input  logic signed [31:0]          point_b_x,
  input  logic signed [31:0]          point_b_y,
  input  logic signed [31:0]          point_b_z,
  input  logic signed [31:0]          point_c_x,
  input  logic signed [31:0]          point_c_y,
  input  logic signed [31:0]          point_c_z,
  input  tfn_pkg::queue_stat_t        qstat,
  output logic                        qpush,
  output tfn_pkg::mid_t               qdata
);
  import tfn_pkg::*;

  logic en;
  logic f1_valid, f2_valid, f3_valid;

  logic signed [DW-1:0] ux, uy, uz, vx, vy, vz;
  logic signed [CW-1:0] p_xa, p_xb, p_ya, p_yb, p_za, p_zb;
  mid_t                 f3;

  // the whole front holds only while a finished beat waits on a full queue
  assign en    = !(f3_valid && qstat.full);
  assign full  = !en;
  assign qpush = f3_valid && en;
  assign qdata = f3;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
      f3_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= push;
      f2_valid <= f1_valid;
      f3_valid <= f2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ux <= {point_b_x[PW-1], point_b_x} - {point_a_x[PW-1], point_a_x};
      uy <= {point_b_y[PW-1], point_b_y} - {point_a_y[PW-1], point_a_y};
      uz <= {point_b_z[PW-1], point_b_z} - {point_a_z[PW-1], point_a_z};
      vx <= {point_b_x[PW-1], point_b_x} - {point_c_x[PW-1], point_c_x};
      vy <= {point_b_y[PW-1], point_b_y} - {point_c_y[PW-1], point_c_y};
      vz <= {point_b_z[PW-1], point_b_z} - {point_c_z[PW-1], point_c_z};

      p_xa <= uy * vz;
      p_xb <= vy * uz;
      p_ya <= vx * uz;
      p_yb <= ux * vz;
      p_za <= ux * vy;
      p_zb <= vx * uy;

      // differences stay inside +-2^65, no wrap at 66 bits
      f3.r_x <= p_xa - p_xb;
      f3.r_y <= p_ya - p_yb;
      f3.r_z <= p_za - p_zb;
      f3.degenerate <= (p_xa == p_xb) && (p_ya == p_yb) && (p_za == p_zb);
    end
  end

endmodule

// ===== hw/rtl/tfn_back.sv =====
// ----------------------------------------------------------------------------
// tfn_back
// Squares the cross product, sums the length, and finds each Q1.14 component
// bit by bit without a square root. Ends in the result register.
// ----------------------------------------------------------------------------
module tfn_back (
  input  logic                 clk,
  input  logic                 rst,
  input  tfn_pkg::queue_stat_t qstat,
  input  tfn_pkg::mid_t        qdata,
  output logic                 qpop,
  output logic                 empty,
  input  logic                 pop,
  output logic signed [15:0]   normal_x,
  output logic signed [15:0]   normal_y,
  output logic signed [15:0]   normal_z,
  output logic                 degenerate
);
  import tfn_pkg::*;

  logic en;
  logic out_valid;

  logic signed [CW-1:0] r_in [LANES];
  logic [MW-1:0]        mag_in [LANES];

  logic              b1_valid, b2_valid, b3_valid;
  logic [MW-1:0]     b1_mag [LANES];
  logic [LANES-1:0]  b1_neg, b2_neg, b3_neg;
  logic              b1_deg, b2_deg, b3_deg;
  logic [2*HIW-1:0]  b2_hh [LANES];
  logic [HIW+LOW-1:0] b2_hl [LANES];
  logic [2*LOW-1:0]  b2_ll [LANES];
  logic [SQW-1:0]    b3_sq [LANES];

  logic              st_valid [NSTEP+1];
  logic [WIDE-1:0]   st_s     [NSTEP+1];
  logic [LANES-1:0]  st_neg   [NSTEP+1];
  logic              st_deg   [NSTEP+1];
  logic [WIDE-1:0]   st_p     [NSTEP+1][LANES];
  logic [WIDE-1:0]   st_qs    [NSTEP+1][LANES];
  logic [WIDE-1:0]   st_t     [NSTEP+1][LANES];
  logic [QW-1:0]     st_q     [NSTEP+1][LANES];

  logic signed [OUTW-1:0] res [LANES];
  logic                   res_deg;

  assign en    = !out_valid || pop;
  assign qpop  = en && !qstat.empty;
  assign empty = !out_valid;

  assign r_in[0] = qdata.r_x;
  assign r_in[1] = qdata.r_y;
  assign r_in[2] = qdata.r_z;

  always_comb begin
    logic [CW-1:0] neg_r;
    for (int i = 0; i < LANES; i++) begin
      neg_r     = CW'(0) - r_in[i];
      mag_in[i] = r_in[i][CW-1] ? neg_r[MW-1:0] : r_in[i][MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid    <= 1'b0;
      b2_valid    <= 1'b0;
      b3_valid    <= 1'b0;
      st_valid[0] <= 1'b0;
    end else if (en) begin
      b1_valid    <= !qstat.empty;
      b2_valid    <= b1_valid;
      b3_valid    <= b2_valid;
      st_valid[0] <= b3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_deg <= qdata.degenerate;
      b2_deg <= b1_deg;
      b3_deg <= b2_deg;
      b2_neg <= b1_neg;
      b3_neg <= b2_neg;
      for (int i = 0; i < LANES; i++) begin
        b1_mag[i] <= mag_in[i];
        b1_neg[i] <= r_in[i][CW-1];
        // magnitude split into a 33-bit high and 32-bit low half
        b2_hh[i] <= b1_mag[i][MW-1:LOW] * b1_mag[i][MW-1:LOW];
        b2_hl[i] <= b1_mag[i][MW-1:LOW] * b1_mag[i][LOW-1:0];
        b2_ll[i] <= b1_mag[i][LOW-1:0] * b1_mag[i][LOW-1:0];
        b3_sq[i] <= (SQW'(b2_hh[i]) << (2 * LOW)) + (SQW'(b2_hl[i]) << (LOW + 1))
                    + SQW'(b2_ll[i]);
      end
      st_s[0]   <= WIDE'(b3_sq[0]) + WIDE'(b3_sq[1]) + WIDE'(b3_sq[2]);
      st_neg[0] <= b3_neg;
      st_deg[0] <= b3_deg;
      for (int i = 0; i < LANES; i++) begin
        st_p[0][i]  <= '0;
        st_qs[0][i] <= '0;
        st_q[0][i]  <= '0;
        st_t[0][i]  <= WIDE'(b3_sq[i]) << FRAC_SHIFT;
      end
    end
  end

  // p holds q*q*s and qs holds q*s, so each trial bit is shifts and adds
  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    localparam int B = NSTEP - 1 - k;

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[k+1] <= 1'b0;
      end else if (en) begin
        st_valid[k+1] <= st_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_s[k+1]   <= st_s[k];
        st_neg[k+1] <= st_neg[k];
        st_deg[k+1] <= st_deg[k];
      end
    end

    for (genvar i = 0; i < LANES; i++) begin : g_lane
      logic [WIDE-1:0] cand;
      logic            take;

      assign cand = st_p[k][i] + (st_qs[k][i] << (B + 1)) + (st_s[k] << (2 * B));
      // once q reaches one, no lower bit may be added
      assign take = !st_q[k][i][QW-1] && (cand <= st_t[k][i]);

      always_ff @(posedge clk) begin
        if (en) begin
          st_p[k+1][i]  <= take ? cand : st_p[k][i];
          st_qs[k+1][i] <= take ? st_qs[k][i] + (st_s[k] << B) : st_qs[k][i];
          st_q[k+1][i]  <= take ? (st_q[k][i] | (QW'(1) << B)) : st_q[k][i];
          st_t[k+1][i]  <= st_t[k][i];
        end
      end
    end
  end

  always_comb begin
    logic [OUTW-1:0] qext;
    res_deg = st_deg[NSTEP];
    for (int i = 0; i < LANES; i++) begin
      qext = {1'b0, st_q[NSTEP][i]};
      if (res_deg) begin
        res[i] = '0;
      end else if (st_neg[NSTEP][i]) begin
        res[i] = OUTW'(0) - qext;
      end else begin
        res[i] = qext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= st_valid[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      normal_x   <= res[0];
      normal_y   <= res[1];
      normal_z   <= res[2];
      degenerate <= res_deg;
    end
  end

endmodule

// ===== hw/rtl/triangle_face_normal_top.sv =====
// ----------------------------------------------------------------------------
// triangle_face_normal_top
// Unit face normal of a triangle, exact cross product, Q1.14 result.
// ----------------------------------------------------------------------------
// Input side is a queue: drive the nine corner coordinates (signed Q16.16)
// with push; a triangle is taken on a clock edge where push is high and
// full is low. Result side is a queue too: while empty is low the oldest
// normal (signed Q1.14, truncated toward zero) and degenerate are on the
// ports, and pop takes it. A triangle with a zero cross product returns
// degenerate high and a zero normal.
// One triangle is taken every cycle and one result leaves every cycle while
// full stays low and pop is high. The accepting edge loads the first of
// three front stages (edge vectors, products, cross product); the triangle
// then passes the middle queue, four stages of squaring and summing, one
// stage per quotient bit (fifteen), and the result register.
// When pop stays low with a result waiting, the back pipeline holds; the
// front keeps filling the middle queue of MID_DEPTH entries and raises full
// once it is full with a finished cross product still waiting.
// Reset empties all pipelines and queues; no clearing pass is needed.
// ----------------------------------------------------------------------------
module triangle_face_normal_top #(
  parameter int MID_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] point_a_x,
  input  logic signed [31:0] point_a_y,
  input  logic signed [31:0] point_a_z,
  input  logic signed [31:0] point_b_x,
  input  logic signed [31:0] point_b_y,
  input  logic signed [31:0] point_b_z,
  input  logic signed [31:0] point_c_x,
  input  logic signed [31:0] point_c_y,
  input  logic signed [31:0] point_c_z,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] normal_x,
  output logic signed [15:0] normal_y,
  output logic signed [15:0] normal_z,
  output logic               degenerate
);
  import tfn_pkg::*;

  queue_stat_t qstat;
  logic        qpush;
  logic        qpop;
  mid_t        qin;
  mid_t        qout;

  tfn_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .point_a_x (point_a_x),
    .point_a_y (point_a_y),
    .point_a_z (point_a_z),
    .point_b_x (point_b_x),
    .point_b_y (point_b_y),
    .point_b_z (point_b_z),
    .point_c_x (point_c_x),
    .point_c_y (point_c_y),
    .point_c_z (point_c_z),
    .qstat     (qstat),
    .qpush     (qpush),
    .qdata     (qin)
  );

  tfn_queue #(
    .DEPTH (MID_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (qpush),
    .din  (qin),
    .rd   (qpop),
    .dout (qout),
    .stat (qstat)
  );

  tfn_back u_back (
    .clk        (clk),
    .rst        (rst),
    .qstat      (qstat),
    .qdata      (qout),
    .qpop       (qpop),
    .empty      (empty),
    .pop        (pop),
    .normal_x   (normal_x),
    .normal_y   (normal_y),
    .normal_z   (normal_z),
    .degenerate (degenerate)
  );

  // middle queue never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(qpush && qstat.full))
    else $error("middle queue written while full");

  // degenerate beats carry a zero normal
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && degenerate) |-> (normal_x == 16'sd0 && normal_y == 16'sd0
                                && normal_z == 16'sd0))
    else $error("degenerate result with nonzero normal");

  // a real normal has at least one nonzero component
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !degenerate) |-> (normal_x != 16'sd0 || normal_y != 16'sd0
                                 || normal_z != 16'sd0))
    else $error("nondegenerate result with zero normal");

  // components stay within one in Q1.14
  a_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (normal_x >= -16'sd16384 && normal_x <= 16'sd16384
                && normal_y >= -16'sd16384 && normal_y <= 16'sd16384
                && normal_z >= -16'sd16384 && normal_z <= 16'sd16384))
    else $error("normal component out of range");

  // reset leaves the result side empty
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> empty)
    else $error("result present right after reset");

endmodule
